// ===== rtl/core/tctq_pkg.sv =====
`timescale 1ns / 1ps

package tctq_pkg;

	// Command codes carried in the mode field.
	localparam logic [1:0] MODE_SERVE      = 2'd0;
	localparam logic [1:0] MODE_ENQ_NORMAL = 2'd1;
	localparam logic [1:0] MODE_ENQ_PRIO   = 2'd2;
	localparam logic [1:0] MODE_IGNORE     = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_ENQ     = 3'd0;
	localparam logic [2:0] ST_SERVED  = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	// Fixed field widths of the two channels.
	localparam int unsigned TICKET_W = 32;
	localparam int unsigned OCC_W    = 5;

	// Input beat.
	typedef struct packed {
		logic [1:0]          mode;
		logic [TICKET_W-1:0] ticket_code;
	} in_item_t;

	// Output beat.
	typedef struct packed {
		logic [2:0]          status;
		logic [TICKET_W-1:0] served_code;
		logic                served_was_priority;
		logic [OCC_W-1:0]    occupancy;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} dp_cmd_t;

endpackage

// ===== rtl/core/tctq_ctrl.sv =====
`timescale 1ns / 1ps

module tctq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output tctq_pkg::dp_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	// The output register can take a new result when it is empty or drains now.
	assign out_free = !out_valid_q || !out_stall;

	// A new item enters when idle, or while the finished result moves out.
	assign in_stall  = !((state_q == S_IDLE) || ((state_q == S_DONE) && out_free));
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd.capture = accept;
		cmd.exec    = (state_q == S_EXEC);
		cmd.load    = (state_q == S_DONE) && out_free;
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				state_next = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_next = accept ? S_EXEC : S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/tctq_dpath.sv =====
`timescale 1ns / 1ps

module tctq_dpath #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned CODE_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tctq_pkg::dp_cmd_t   cmd,
	input  tctq_pkg::in_item_t  in_item,
	output tctq_pkg::out_item_t out_item
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SW = (CODE_BITS < tctq_pkg::TICKET_W) ?
		CODE_BITS : tctq_pkg::TICKET_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	// Ticket stores, one per class.
	logic [SW-1:0] prio_mem [QUEUE_DEPTH];
	logic [SW-1:0] norm_mem [QUEUE_DEPTH];

	logic [1:0]    mode_q;
	logic [SW-1:0] code_q;
	logic [AW-1:0] p_head_q, p_tail_q, n_head_q, n_tail_q;
	logic [CW-1:0] p_cnt_q, n_cnt_q;
	logic [SW-1:0] prio_rd_q, norm_rd_q;
	logic [2:0]    status_q;
	logic          was_prio_q;
	logic [tctq_pkg::OCC_W-1:0] occ_q;
	tctq_pkg::out_item_t out_q;

	logic          full;
	logic          pop_p, pop_n, push_p, push_n;
	logic [CW-1:0] total, total_next;
	logic [2:0]    status_next;
	logic [CW+tctq_pkg::OCC_W-1:0] total_ext;

	// Ring index advance with wrap at the last entry.
	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
		logic [AW-1:0] nxt;
		nxt = (idx == LAST_IDX) ? '0 : idx + AW'(1);
		return nxt;
	endfunction

	// Capture the accepted command.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_item.mode;
			code_q <= in_item.ticket_code[SW-1:0];
		end
	end

	// Decide the action from the class counts.
	always_comb begin
		total  = p_cnt_q + n_cnt_q;
		full   = (total == FULL_CNT);
		pop_p  = 1'b0;
		pop_n  = 1'b0;
		push_p = 1'b0;
		push_n = 1'b0;
		status_next = tctq_pkg::ST_IGNORED;
		total_next  = total;
		case (mode_q) inside
			tctq_pkg::MODE_SERVE: begin
				if (p_cnt_q != '0) begin
					pop_p       = 1'b1;
					status_next = tctq_pkg::ST_SERVED;
					total_next  = total - CW'(1);
				end else if (n_cnt_q != '0) begin
					pop_n       = 1'b1;
					status_next = tctq_pkg::ST_SERVED;
					total_next  = total - CW'(1);
				end else begin
					status_next = tctq_pkg::ST_EMPTY;
				end
			end
			tctq_pkg::MODE_ENQ_NORMAL, tctq_pkg::MODE_ENQ_PRIO: begin
				if (full) begin
					status_next = tctq_pkg::ST_FULL;
				end else begin
					push_p      = (mode_q == tctq_pkg::MODE_ENQ_PRIO);
					push_n      = (mode_q == tctq_pkg::MODE_ENQ_NORMAL);
					status_next = tctq_pkg::ST_ENQ;
					total_next  = total + CW'(1);
				end
			end
			default: begin
				status_next = tctq_pkg::ST_IGNORED;
			end
		endcase
		total_ext = (CW + tctq_pkg::OCC_W)'(total_next);
	end

	// Pointers and counts of both classes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_head_q <= '0;
			p_tail_q <= '0;
			n_head_q <= '0;
			n_tail_q <= '0;
			p_cnt_q  <= '0;
			n_cnt_q  <= '0;
		end else if (cmd.exec) begin
			if (pop_p) begin
				p_head_q <= wrap_next(p_head_q);
				p_cnt_q  <= p_cnt_q - CW'(1);
			end
			if (pop_n) begin
				n_head_q <= wrap_next(n_head_q);
				n_cnt_q  <= n_cnt_q - CW'(1);
			end
			if (push_p) begin
				p_tail_q <= wrap_next(p_tail_q);
				p_cnt_q  <= p_cnt_q + CW'(1);
			end
			if (push_n) begin
				n_tail_q <= wrap_next(n_tail_q);
				n_cnt_q  <= n_cnt_q + CW'(1);
			end
		end
	end

	// Store writes and registered head reads.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (push_p) begin
				prio_mem[p_tail_q] <= code_q;
			end
			if (push_n) begin
				norm_mem[n_tail_q] <= code_q;
			end
			prio_rd_q  <= prio_mem[p_head_q];
			norm_rd_q  <= norm_mem[n_head_q];
			status_q   <= status_next;
			was_prio_q <= pop_p;
			occ_q      <= total_ext[tctq_pkg::OCC_W-1:0];
		end
	end

	// Output register; the served code is zero unless a ticket left.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.status              <= status_q;
			out_q.served_was_priority <= was_prio_q;
			out_q.occupancy           <= occ_q;
			if (status_q == tctq_pkg::ST_SERVED) begin
				out_q.served_code <= was_prio_q ? tctq_pkg::TICKET_W'(prio_rd_q) :
					tctq_pkg::TICKET_W'(norm_rd_q);
			end else begin
				out_q.served_code <= '0;
			end
		end
	end

	assign out_item = out_q;

endmodule

// ===== rtl/core/two_class_ticket_queue.sv =====
`timescale 1ns / 1ps
// Flow: a result reaches the output register through capture, execute and load; the load waits while the
// output register holds a stalled beat. A new item is accepted when idle or while the previous result loads; each item
// holds one controller pass of execute (store access and pointer update) and load.
// Reset: asynchronous, active low; both classes empty, all ring indices at zero.
// Ticket stores are not cleared; only entries already written are ever served.

module two_class_ticket_queue #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned CODE_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tctq_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output tctq_pkg::out_item_t out_item
);

	tctq_pkg::dp_cmd_t cmd;

	// Sequencing of capture, execute and output load.
	tctq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Ticket stores, ring pointers and result registers.
	tctq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CODE_BITS   (CODE_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.out_item (out_item)
	);

endmodule

// ===== sim/two_class_ticket_queue_test.sv =====
`timescale 1ns / 1ps

module two_class_ticket_queue_test;

	localparam int unsigned TICKET_DEPTH = 16;
	localparam int unsigned MAX_SHOWN    = 40;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	tctq_pkg::in_item_t  in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	tctq_pkg::out_item_t out_item;

	// Predicted queue contents, one line per class, oldest ticket at the front.
	logic [tctq_pkg::TICKET_W-1:0] prio_line[$];
	logic [tctq_pkg::TICKET_W-1:0] norm_line[$];
	tctq_pkg::out_item_t           pending_results[$];

	// Idling controls shared by the tests and the stall driver.
	bit          quiet_in;
	bit          quiet_out;
	int unsigned stall_left;

	int unsigned err_count;
	int unsigned sent_count;
	int unsigned checked_count;
	int unsigned enq_count;
	int unsigned served_prio_count;
	int unsigned served_norm_count;
	int unsigned empty_count;
	int unsigned full_count;
	int unsigned ignored_count;

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	two_class_ticket_queue #(
		.QUEUE_DEPTH(TICKET_DEPTH),
		.CODE_BITS  (tctq_pkg::TICKET_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_error(input string msg);
		if (err_count < MAX_SHOWN) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
		err_count++;
	endtask

	// Applies one command to the predicted queue and returns the expected result beat.
	function automatic tctq_pkg::out_item_t predict_ticket(input tctq_pkg::in_item_t cmd);
		tctq_pkg::out_item_t res;
		res = '0;
		case (cmd.mode) inside
			tctq_pkg::MODE_SERVE: begin
				if (prio_line.size() != 0) begin
					res.status              = tctq_pkg::ST_SERVED;
					res.served_code         = prio_line.pop_front();
					res.served_was_priority = 1'b1;
				end else if (norm_line.size() != 0) begin
					res.status      = tctq_pkg::ST_SERVED;
					res.served_code = norm_line.pop_front();
				end else begin
					res.status = tctq_pkg::ST_EMPTY;
				end
			end
			tctq_pkg::MODE_ENQ_NORMAL, tctq_pkg::MODE_ENQ_PRIO: begin
				// Both classes share one capacity.
				if (prio_line.size() + norm_line.size() >= TICKET_DEPTH) begin
					res.status = tctq_pkg::ST_FULL;
				end else if (cmd.mode == tctq_pkg::MODE_ENQ_PRIO) begin
					prio_line.push_back(cmd.ticket_code);
					res.status = tctq_pkg::ST_ENQ;
				end else begin
					norm_line.push_back(cmd.ticket_code);
					res.status = tctq_pkg::ST_ENQ;
				end
			end
			default: begin
				res.status = tctq_pkg::ST_IGNORED;
			end
		endcase
		res.occupancy = tctq_pkg::OCC_W'(prio_line.size() + norm_line.size());
		return res;
	endfunction

	// Sends one command beat after an optional idle gap and records its prediction.
	task automatic send_ticket(input logic [1:0] mode,
			input logic [tctq_pkg::TICKET_W-1:0] code, input int unsigned gap);
		tctq_pkg::in_item_t cmd;
		cmd.mode        = mode;
		cmd.ticket_code = code;
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= cmd;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_results.push_back(predict_ticket(cmd));
		sent_count++;
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Stops sending until every outstanding result has been checked.
	task automatic wait_drained();
		hold_input();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Mostly back-to-back beats, some short gaps, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_in) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(30, 8);
	endfunction

	// Ticket codes lean toward the all-zero and all-one extremes now and then.
	function automatic logic [tctq_pkg::TICKET_W-1:0] pick_code();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6) begin
			return '0;
		end
		if (r < 12) begin
			return '1;
		end
		return $urandom();
	endfunction

	function automatic logic [1:0] pick_enq_mode(input int unsigned prio_pct);
		return ($urandom_range(99) < prio_pct) ? tctq_pkg::MODE_ENQ_PRIO :
			tctq_pkg::MODE_ENQ_NORMAL;
	endfunction

	// Output side stall: short bursts mostly, occasionally a long one.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!quiet_out && $urandom_range(99) < 20) begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 8) - 1
				: $urandom_range(3, 1) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compares every accepted result beat with the oldest prediction.
	always @(posedge clk) begin : result_check
		tctq_pkg::out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result beat with nothing expected, status %0d",
					out_item.status));
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (out_item.status !== want.status) begin
					report_error($sformatf("result %0d: status %0d, expected %0d",
						checked_count, out_item.status, want.status));
				end
				if (out_item.served_code !== want.served_code) begin
					report_error($sformatf("result %0d: served_code %h, expected %h",
						checked_count, out_item.served_code, want.served_code));
				end
				if (out_item.served_was_priority !== want.served_was_priority) begin
					report_error($sformatf("result %0d: served_was_priority %b, expected %b",
						checked_count, out_item.served_was_priority,
						want.served_was_priority));
				end
				if (out_item.occupancy !== want.occupancy) begin
					report_error($sformatf("result %0d: occupancy %0d, expected %0d",
						checked_count, out_item.occupancy, want.occupancy));
				end
				case (want.status)
					tctq_pkg::ST_ENQ: begin
						enq_count++;
					end
					tctq_pkg::ST_SERVED: begin
						if (want.served_was_priority) begin
							served_prio_count++;
						end else begin
							served_norm_count++;
						end
					end
					tctq_pkg::ST_EMPTY: begin
						empty_count++;
					end
					tctq_pkg::ST_FULL: begin
						full_count++;
					end
					default: begin
						ignored_count++;
					end
				endcase
			end
		end
	end

	// Empty serve, ignored commands, code extremes and the priority-first serve order.
	task automatic test_directed_basics();
		quiet_in = 1'b1;
		send_ticket(tctq_pkg::MODE_SERVE, '1, 0);
		send_ticket(tctq_pkg::MODE_IGNORE, '1, 0);
		send_ticket(tctq_pkg::MODE_IGNORE, '0, 0);
		send_ticket(tctq_pkg::MODE_ENQ_NORMAL, 32'h0000_0000, 0);
		send_ticket(tctq_pkg::MODE_ENQ_NORMAL, 32'hFFFF_FFFF, 0);
		send_ticket(tctq_pkg::MODE_ENQ_PRIO, 32'hA5A5_5A5A, 0);
		send_ticket(tctq_pkg::MODE_ENQ_NORMAL, 32'h1234_5678, 0);
		send_ticket(tctq_pkg::MODE_ENQ_PRIO, 32'h8000_0001, 0);
		// An ignored command must leave a non-empty queue alone.
		send_ticket(tctq_pkg::MODE_IGNORE, 32'hDEAD_BEEF, 0);
		repeat (5) send_ticket(tctq_pkg::MODE_SERVE, 32'h5555_AAAA, 0);
		send_ticket(tctq_pkg::MODE_SERVE, '0, 0);
		quiet_in = 1'b0;
	endtask

	// Fills to capacity, pushes against the full queue, then drains past empty.
	task automatic test_fill_and_drain(input int unsigned rounds);
		int unsigned prio_pct;
		for (int unsigned r = 0; r < rounds; r++) begin
			quiet_in  = (r % 2 == 0);
			quiet_out = (r == 0);
			prio_pct  = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(90, 10);
			repeat (TICKET_DEPTH) send_ticket(pick_enq_mode(prio_pct), pick_code(), pick_gap());
			repeat ($urandom_range(3, 1)) send_ticket(pick_enq_mode(50), pick_code(), pick_gap());
			// One out, one in: the refill lands at the full mark again.
			send_ticket(tctq_pkg::MODE_SERVE, pick_code(), pick_gap());
			send_ticket(pick_enq_mode(prio_pct), pick_code(), pick_gap());
			send_ticket(pick_enq_mode(prio_pct), pick_code(), pick_gap());
			repeat (TICKET_DEPTH + $urandom_range(2, 1)) begin
				send_ticket(tctq_pkg::MODE_SERVE, pick_code(), pick_gap());
			end
		end
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
	endtask

	// Random command streams whose enqueue bias moves occupancy between empty and full.
	task automatic test_random_mix(input int unsigned phases, input int unsigned per_phase);
		int unsigned enq_bias[6] = '{50, 70, 30, 85, 15, 55};
		int unsigned enq_pct;
		int unsigned prio_pct;
		int unsigned r;
		logic [1:0]  mode;
		for (int unsigned p = 0; p < phases; p++) begin
			enq_pct   = enq_bias[p % 6];
			prio_pct  = $urandom_range(90, 10);
			quiet_in  = ($urandom_range(3) == 0);
			quiet_out = ($urandom_range(3) == 0);
			repeat (per_phase) begin
				r = $urandom_range(99);
				if (r < 5) begin
					mode = tctq_pkg::MODE_IGNORE;
				end else if (r < 5 + enq_pct) begin
					mode = pick_enq_mode(prio_pct);
				end else begin
					mode = tctq_pkg::MODE_SERVE;
				end
				send_ticket(mode, pick_code(), pick_gap());
			end
			// Let the pipeline run dry between some phases.
			if (p % 3 == 1) begin
				wait_drained();
			end
		end
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
	endtask

	// Test sequence.
	initial begin
		int unsigned drain_cycles;
		drain_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_basics();
		test_fill_and_drain(6);
		test_random_mix(9, 180);
		hold_input();
		while (pending_results.size() != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (pending_results.size() != 0) begin
			report_error($sformatf("%0d expected results never arrived",
				pending_results.size()));
		end
		repeat (10) @(posedge clk);
		$display("Sent %0d commands: %0d enqueued, %0d full rejections, %0d ignored.",
			sent_count, enq_count, full_count, ignored_count);
		$display("Served %0d priority and %0d normal tickets, %0d empty serves; %0d errors.",
			served_prio_count, served_norm_count, empty_count, err_count);
		if (err_count == 0) begin
			$display("two_class_ticket_queue_test: done, clean");
		end else begin
			$display("two_class_ticket_queue_test: done, errors");
		end
		$finish;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#3000000;
		$display("Run stopped by timeout.");
		$display("two_class_ticket_queue_test: done, errors");
		$finish;
	end

endmodule
